>>> hdl/bfrp_pkg.sv
`timescale 1ns / 1ps
package bfrp_pkg;

	localparam int MaxBytes   = 8192;
	localparam int AddrW      = $clog2(MaxBytes);
	localparam int PosW       = AddrW + 3;
	localparam int TotalW     = PosW + 1;
	localparam int ProbeLimit = 30;
	localparam int BytesW     = 14;
	localparam int ProbeW     = 5;

	// register indexes on the configuration port
	localparam logic CFG_FILTER_BYTES = 1'b0;
	localparam logic CFG_PROBE_COUNT  = 1'b1;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CHECK  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] hash_value;
	} req_t;

	// clamp size to 1..MaxBytes and return the bit count
	function automatic logic [TotalW-1:0] size_bits(input logic [BytesW-1:0] n);
		logic [TotalW-1:0] b;
		b = TotalW'(n);
		if (n == '0)
			b = TotalW'(1);
		else if (32'(n) > MaxBytes)
			b = TotalW'(MaxBytes);
		return {b[TotalW-4:0], 3'b000};
	endfunction

	// clamp probe count to 1..ProbeLimit
	function automatic logic [ProbeW-1:0] eff_probes(input logic [ProbeW-1:0] k);
		logic [ProbeW-1:0] r;
		r = k;
		if (k == '0)
			r = ProbeW'(1);
		else if (k > ProbeW'(ProbeLimit))
			r = ProbeW'(ProbeLimit);
		return r;
	endfunction

endpackage

>>> hdl/bloom_filter_rotate_probe_top.sv
`timescale 1ns / 1ps
// Bloom filter over an 8192-byte bit store. Each request (insert or check of a
// 32-bit hash) makes probe_count probes; each probe reduces the hash modulo
// the filter's bit count in a shared remainder unit (4 bits a cycle) and then
// reads the store; a check stops at the first clear bit, and a check before
// any insert answers without probing. After reset the store is swept to zero
// one byte a cycle, during which the engine takes no request (the queue still
// fills, and configuration writes are still taken). A two-entry queue sits
// before the engine.
module bloom_filter_rotate_probe_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [31:0] hash_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        maybe_present
);
	import bfrp_pkg::*;

	logic [BytesW-1:0] filter_bytes_q;
	logic [ProbeW-1:0] probe_count_q;
	logic              q_valid;
	req_t              q_head;
	logic              q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bytes_q <= BytesW'(MaxBytes);
			probe_count_q  <= ProbeW'(6);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILTER_BYTES: filter_bytes_q <= cfg_data;
				CFG_PROBE_COUNT:  probe_count_q  <= cfg_data[ProbeW-1:0];
				default: ;
			endcase
		end
	end

	bfrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.hash_value (hash_value),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	bfrp_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.total         (size_bits(filter_bytes_q)),
		.probes        (eff_probes(probe_count_q)),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.maybe_present (maybe_present)
	);

endmodule

>>> hdl/bfrp_front.sv
`timescale 1ns / 1ps
module bfrp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          command,
	input  logic [31:0]   hash_value,
	output logic          q_valid,
	output bfrp_pkg::req_t q_head,
	input  logic          q_pop
);
	import bfrp_pkg::*;

	req_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = slot_q[rd_q];

	// two-entry request queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				slot_q[wr_q] <= '{command: command, hash_value: hash_value};
				wr_q         <= ~wr_q;
			end
			if (q_pop && q_valid)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

endmodule

>>> hdl/bfrp_engine.sv
`timescale 1ns / 1ps
module bfrp_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  bfrp_pkg::req_t               q_head,
	output logic                         q_pop,
	input  logic [bfrp_pkg::TotalW-1:0]  total,
	input  logic [bfrp_pkg::ProbeW-1:0]  probes,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         maybe_present
);
	import bfrp_pkg::*;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DIV, S_READ, S_CHECK, S_DONE} state_t;

	state_t            state_q;
	logic [AddrW-1:0]  clr_q;
	logic              cmd_q;
	logic [31:0]       hash_q;
	logic [31:0]       div_q;
	logic [TotalW-1:0] rem_q;
	logic [2:0]        cnt_q;
	logic [ProbeW-1:0] probe_q;
	logic              present_q;
	logic              loaded_q;
	logic              res_valid_q;
	logic              res_q;

	logic [7:0]        mem [MaxBytes];
	logic [7:0]        rd_q;
	logic              mem_we;
	logic [AddrW-1:0]  mem_waddr;
	logic [7:0]        mem_wdata;
	logic [7:0]        bit_mask;
	logic [TotalW-1:0] rem_next;
	logic [31:0]       hash_rot;

	assign q_pop         = (state_q == S_IDLE) && q_valid;
	assign out_valid     = res_valid_q;
	assign maybe_present = res_q;
	assign bit_mask      = 8'd1 << rem_q[2:0];
	assign hash_rot      = {hash_q[0], hash_q[31:1]};

	// four restoring remainder steps per cycle
	always_comb begin
		logic [TotalW:0] t;
		rem_next = rem_q;
		for (int i = 0; i < 4; i++) begin
			t = {rem_next, div_q[31-i]};
			if (t >= {1'b0, total})
				t = t - {1'b0, total};
			rem_next = t[TotalW-1:0];
		end
	end

	// store write: clearing sweep or insert read-modify-write
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 8'd0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == S_CHECK && cmd_q == CMD_INSERT) begin
			mem_we    = 1'b1;
			mem_waddr = rem_q[PosW-1:3];
			mem_wdata = rd_q | bit_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[rem_q[PosW-1:3]];
	end

	// probe sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cmd_q       <= CMD_INSERT;
			hash_q      <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			probe_q     <= '0;
			present_q   <= 1'b1;
			loaded_q    <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= 1'b0;
		end else begin
			// the done state reloads the result register itself
			if (res_valid_q && out_ready && state_q != S_DONE)
				res_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AddrW'(MaxBytes - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						cmd_q     <= q_head.command;
						hash_q    <= q_head.hash_value;
						div_q     <= q_head.hash_value;
						rem_q     <= '0;
						cnt_q     <= '0;
						probe_q   <= '0;
						present_q <= 1'b1;
						if (q_head.command == CMD_CHECK && !loaded_q)
							state_q <= S_DONE;
						else
							state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_next;
					div_q <= {div_q[27:0], 4'd0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd7)
						state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (cmd_q == CMD_INSERT)
						loaded_q <= 1'b1;
					if (cmd_q == CMD_CHECK && (rd_q & bit_mask) == 8'd0) begin
						present_q <= 1'b0;
						state_q   <= S_DONE;
					end else if (probe_q == probes - 1'b1) begin
						state_q <= S_DONE;
					end else begin
						probe_q <= probe_q + 1'b1;
						hash_q  <= hash_rot;
						div_q   <= hash_rot;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DONE: begin
					if (!res_valid_q || out_ready) begin
						res_valid_q <= 1'b1;
						res_q       <= (cmd_q == CMD_CHECK) && present_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// requests are taken only between items
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == S_IDLE && !res_valid_q) || (state_q == S_IDLE))
		else $error("pop outside idle");
	// remainder is below the bit count when the store is read
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (rem_q < total))
		else $error("probe position out of range");
	// probe index stays inside the configured count
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (probe_q < probes))
		else $error("probe index overrun");
	// an insert always leaves the filter loaded
	a_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && cmd_q == CMD_INSERT) |=> loaded_q)
		else $error("loaded flag not set by insert");

endmodule
